/* rtl/lsp_pkg.sv */
`default_nettype none
package lsp_pkg;

  localparam int MAX_PROCS   = 16;
  localparam int TICKET_BITS = 8;

  localparam int OP_W    = 2;
  localparam int ID_W    = 8;
  localparam int TCIN_W  = 8;
  localparam int RAND_W  = 31;
  localparam int TKT_W   = TICKET_BITS;
  localparam int CNT_W   = $clog2(MAX_PROCS + 1);
  localparam int TOTAL_W = TICKET_BITS + CNT_W;
  localparam int STEP_W  = $clog2(RAND_W + 1);

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_SEL   = 2'd2;

  // token that ripples down the row of cells
  typedef struct packed {
    logic               sel;
    logic [TOTAL_W-1:0] val;
    logic               found;
    logic [ID_W-1:0]    winner;
  } link_t;

endpackage
`default_nettype wire

/* rtl/lsp_if.sv */
`default_nettype none
interface lsp_req_if;
  import lsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [ID_W-1:0]   proc_id;
  logic [TCIN_W-1:0] ticket_count;
  logic [RAND_W-1:0] random_value;

  modport source (output valid, output opcode, output proc_id, output ticket_count,
                  output random_value, input ready);
  modport sink (input valid, input opcode, input proc_id, input ticket_count,
                input random_value, output ready);
endinterface

interface lsp_rsp_if;
  import lsp_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] winner_id;
  logic            no_winner;
  logic            table_full;

  modport source (output valid, output winner_id, output no_winner, output table_full,
                  input ready);
  modport sink (input valid, input winner_id, input no_winner, input table_full,
                output ready);
endinterface
`default_nettype wire

/* rtl/lottery_scheduler_pick.sv */
// weighted lottery picker: one request in, one result out
// req channel: opcode, proc_id, ticket_count, random_value; res channel:
// winner_id, no_winner, table_full. one request is worked on at a time and
// req.ready is high only while the block waits for a new request.
// add and the unused opcode go straight from accept to the result state.
// allocate sends a running sum down the row of MAX_PROCS cells, one cell a
// cycle, and commits the sum it collects.
// select first reduces random_value by the committed total in a one bit per
// cycle remainder unit, then walks the cell row.
// a finished result sits in an output register; a new request is taken while
// it waits, and its own result is held back until the receiver takes the old
// one. reset empties the table and clears the committed total; the entries
// themselves are not cleared.
`default_nettype none
module lottery_scheduler_pick (
  input logic           clk,
  input logic           rst,
  lsp_req_if.sink       req,
  lsp_rsp_if.source     rsp
);
  import lsp_pkg::*;

  typedef enum logic [1:0] {IDLE, MODW, WALK, RES} state_t;

  state_t             state;
  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   committed_count;
  logic [TOTAL_W-1:0] committed_total;
  logic [CNT_W-1:0]   cnt;
  link_t              head;
  link_t              links [MAX_PROCS];
  logic [MAX_PROCS-1:0] we;
  logic [MAX_PROCS-1:0] en;

  logic [ID_W-1:0] res_winner;
  logic            res_none;
  logic            res_full;
  logic            out_valid;
  logic [ID_W-1:0] out_winner;
  logic            out_none;
  logic            out_full;

  logic             accept;
  logic             full;
  logic             mod_start;
  logic             mod_done;
  logic [TOTAL_W-1:0] mod_rem;

  assign req.ready = (state == IDLE);
  assign accept    = req.valid && (state == IDLE);
  assign full      = (entry_count == CNT_W'(MAX_PROCS));

  assign mod_start = accept && (req.opcode == OP_SEL) && (committed_total != '0);

  lsp_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (req.random_value),
    .divisor  (committed_total),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    assign we[i] = accept && (req.opcode == OP_ADD) && !full &&
                   (entry_count == CNT_W'(i));
    // select sees committed entries, allocate sees pending ones
    assign en[i] = head.sel ? (CNT_W'(i) < committed_count)
                            : (CNT_W'(i) >= committed_count) && (CNT_W'(i) < entry_count);

    lsp_cell u_cell (
      .clk        (clk),
      .we         (we[i]),
      .wr_id      (req.proc_id),
      .wr_tickets (TKT_W'(req.ticket_count)),
      .en         (en[i]),
      .link_in    ((i == 0) ? head : links[(i == 0) ? 0 : i - 1]),
      .link_out   (links[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      entry_count     <= '0;
      committed_count <= '0;
      committed_total <= '0;
      out_valid       <= 1'b0;
      cnt             <= '0;
      head            <= '0;
      res_winner      <= '0;
      res_none        <= 1'b0;
      res_full        <= 1'b0;
      out_winner      <= '0;
      out_none        <= 1'b0;
      out_full        <= 1'b0;
    end else begin
      // in RES the output register is reloaded below
      if (out_valid && rsp.ready && (state != RES)) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req.valid) begin
            res_winner <= '0;
            res_none   <= 1'b0;
            res_full   <= 1'b0;
            case (req.opcode)
              OP_ADD: begin
                if (full) begin
                  res_full <= 1'b1;
                end else begin
                  entry_count <= entry_count + 1'b1;
                end
                state <= RES;
              end
              OP_ALLOC: begin
                head  <= '{sel: 1'b0, val: committed_total, found: 1'b0, winner: '0};
                cnt   <= '0;
                state <= WALK;
              end
              OP_SEL: begin
                if (committed_total == '0) begin
                  res_none <= 1'b1;
                  state    <= RES;
                end else begin
                  state <= MODW;
                end
              end
              default: state <= RES;
            endcase
          end
        end
        MODW: begin
          if (mod_done) begin
            head  <= '{sel: 1'b1, val: mod_rem, found: 1'b0, winner: '0};
            cnt   <= '0;
            state <= WALK;
          end
        end
        WALK: begin
          cnt <= cnt + 1'b1;
          // token has left the last cell
          if (cnt == CNT_W'(MAX_PROCS)) begin
            if (head.sel) begin
              res_winner <= links[MAX_PROCS-1].found ? links[MAX_PROCS-1].winner : '0;
            end else begin
              committed_total <= links[MAX_PROCS-1].val;
              committed_count <= entry_count;
            end
            state <= RES;
          end
        end
        RES: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_winner <= res_winner;
            out_none   <= res_none;
            out_full   <= res_full;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.winner_id  = out_winner;
  assign rsp.no_winner  = out_none;
  assign rsp.table_full = out_full;

  a_commit_le_entries: assert property (@(posedge clk) disable iff (rst)
    committed_count <= entry_count)
    else $error("committed count ahead of entry count");

  a_entries_bounded: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_PROCS))
    else $error("entry count beyond table size");

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_none |-> (out_winner == '0) && !out_full)
    else $error("no-winner result carries other flags");

  a_mod_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == MODW)
    else $error("remainder finished outside its wait state");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    state == WALK |-> cnt <= CNT_W'(MAX_PROCS))
    else $error("walk ran past the last cell");

endmodule
`default_nettype wire

/* rtl/lsp_cell.sv */
`default_nettype none
module lsp_cell (
  input  logic                      clk,
  input  logic                      we,
  input  logic [lsp_pkg::ID_W-1:0]  wr_id,
  input  logic [lsp_pkg::TKT_W-1:0] wr_tickets,
  input  logic                      en,
  input  lsp_pkg::link_t            link_in,
  output lsp_pkg::link_t            link_out
);
  import lsp_pkg::*;

  logic [ID_W-1:0]  id;
  logic [TKT_W-1:0] tickets;
  link_t            link_next;

  always_comb begin
    link_next = link_in;
    if (en) begin
      if (link_in.sel) begin
        // walk: claim the index if it falls in this range, else skip past it
        if (!link_in.found) begin
          if (link_in.val < TOTAL_W'(tickets)) begin
            link_next.found  = 1'b1;
            link_next.winner = id;
          end else begin
            link_next.val = link_in.val - TOTAL_W'(tickets);
          end
        end
      end else begin
        link_next.val = link_in.val + TOTAL_W'(tickets);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      id      <= wr_id;
      tickets <= wr_tickets;
    end
    link_out <= link_next;
  end

endmodule
`default_nettype wire

/* rtl/lsp_mod.sv */
`default_nettype none
module lsp_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lsp_pkg::RAND_W-1:0]  dividend,
  input  logic [lsp_pkg::TOTAL_W-1:0] divisor,
  output logic                        done,
  output logic [lsp_pkg::TOTAL_W-1:0] rem
);
  import lsp_pkg::*;

  logic [RAND_W-1:0] quo;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [TOTAL_W:0]  trial;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem, quo[RAND_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo   <= dividend;
        rem   <= '0;
        steps <= STEP_W'(RAND_W);
        busy  <= 1'b1;
      end else if (busy) begin
        quo <= quo << 1;
        if (trial >= {1'b0, divisor}) begin
          rem <= TOTAL_W'(trial - {1'b0, divisor});
        end else begin
          rem <= TOTAL_W'(trial);
        end
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* tb/sv/lsp_pick_check.sv */
`default_nettype none
module lsp_pick_check
  import lsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lsp_req_if          req,
  lsp_rsp_if          rsp,
  output int unsigned fail_count,
  output int unsigned open_count,
  output int unsigned result_count
);

  typedef struct packed {
    logic [ID_W-1:0] winner;
    logic            no_win;
    logic            dropped;
  } pick_result_t;

  // shadow copy of the ticket table
  logic [ID_W-1:0]  slot_id  [MAX_PROCS];
  logic [TKT_W-1:0] slot_tkt [MAX_PROCS];
  int unsigned      n_stored;
  int unsigned      n_committed;
  int unsigned      pool_total;

  pick_result_t     expected_picks [$];
  int unsigned      n_fail;
  int unsigned      n_results;

  function automatic pick_result_t predict_pick(input logic [OP_W-1:0]   op,
                                                input logic [ID_W-1:0]   pid,
                                                input logic [TCIN_W-1:0] tickets,
                                                input logic [RAND_W-1:0] draw);
    pick_result_t res;
    logic [31:0]  spot;
    logic [31:0]  base;
    logic         hit;
    res = '0;
    case (op)
      OP_ADD: begin
        if (n_stored >= MAX_PROCS) begin
          res.dropped = 1'b1;
        end else begin
          slot_id[n_stored]  = pid;
          slot_tkt[n_stored] = tickets[TKT_W-1:0];
          n_stored++;
        end
      end
      OP_ALLOC: begin
        while (n_committed < n_stored) begin
          pool_total += slot_tkt[n_committed];
          n_committed++;
        end
      end
      OP_SEL: begin
        if (pool_total == 0) begin
          res.no_win = 1'b1;
        end else begin
          spot = 32'(draw) % pool_total;
          base = '0;
          hit  = 1'b0;
          // walk the committed entries in arrival order, zero-ticket ones never hit
          for (int i = 0; i < MAX_PROCS; i++) begin
            if (!hit && i < n_committed) begin
              if (spot < base + 32'(slot_tkt[i])) begin
                res.winner = slot_id[i];
                hit        = 1'b1;
              end
              base += 32'(slot_tkt[i]);
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    pick_result_t got;
    pick_result_t want;
    if (rst) begin
      n_stored    = 0;
      n_committed = 0;
      pool_total  = 0;
      n_fail      = 0;
      n_results   = 0;
      expected_picks.delete();
    end else begin
      // results first: a request taken at this edge cannot have its result yet
      if (rsp.valid && rsp.ready) begin
        got.winner  = rsp.winner_id;
        got.no_win  = rsp.no_winner;
        got.dropped = rsp.table_full;
        n_results++;
        if (expected_picks.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: unexpected result winner %0d no_winner %0b table_full %0b",
                     $realtime, got.winner, got.no_win, got.dropped);
        end else begin
          want = expected_picks.pop_front();
          if (got.winner !== want.winner || got.no_win !== want.no_win ||
              got.dropped !== want.dropped) begin
            n_fail++;
            if (n_fail <= 10)
              $display({"%0t: result %0d expected winner %0d no_winner %0b ",
                        "table_full %0b, got winner %0d no_winner %0b table_full %0b"},
                       $realtime, n_results, want.winner, want.no_win, want.dropped,
                       got.winner, got.no_win, got.dropped);
          end
        end
      end
      if (req.valid && req.ready)
        expected_picks.insert(expected_picks.size(),
                              predict_pick(req.opcode, req.proc_id,
                                           req.ticket_count, req.random_value));
    end
    fail_count   <= n_fail;
    open_count   <= expected_picks.size();
    result_count <= n_results;
  end

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none
module tb_top;
  import lsp_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_REQS   = 470;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lsp_req_if req_ch ();
  lsp_rsp_if rsp_ch ();

  int unsigned pick_fail;
  int unsigned pick_open;
  int unsigned pick_results;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_orders = 0;
  int unsigned holds_served = 0;
  int unsigned adds_sent = 0;
  int unsigned op_tally [4] = '{0, 0, 0, 0};
  int unsigned quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lottery_scheduler_pick u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  lsp_pick_check u_check (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fail_count   (pick_fail),
    .open_count   (pick_open),
    .result_count (pick_results)
  );

  task automatic send_request(input logic [OP_W-1:0]   op,
                              input logic [ID_W-1:0]   pid,
                              input logic [TCIN_W-1:0] tc,
                              input logic [RAND_W-1:0] rv);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= op;
    req_ch.proc_id      <= pid;
    req_ch.ticket_count <= tc;
    req_ch.random_value <= rv;
    do @(posedge clk); while (!req_ch.ready);
    op_tally[op]++;
    if (op == OP_ADD)
      adds_sent++;
  endtask

  // receiver: random stalls, plus one long hold-off on demand
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_orders) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holds_served++;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results still due",
               quiet_cycles, pick_open);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [OP_W-1:0]   op;
    logic [TCIN_W-1:0] tc;
    logic [RAND_W-1:0] rv;
    int unsigned       roll;
    req_ch.valid        <= 1'b0;
    req_ch.opcode       <= OP_ADD;
    req_ch.proc_id      <= '0;
    req_ch.ticket_count <= '0;
    req_ch.random_value <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty lottery, allocate with nothing pending, unused opcode
    send_request(OP_SEL,    8'h00, 8'h00, 31'd0);
    send_request(OP_ALLOC,  8'h00, 8'h00, 31'd0);
    send_request(OP_UNUSED, 8'hFF, 8'hFF, 31'h7FFF_FFFF);
    // zero-ticket entry first, then the extremes
    send_request(OP_ADD,    8'h00, 8'h00, 31'd0);
    send_request(OP_ADD,    8'hFF, 8'hFF, 31'h7FFF_FFFF);
    // pending tickets do not count before allocate
    send_request(OP_SEL,    8'h00, 8'h00, 31'd5);
    send_request(OP_ALLOC,  8'h00, 8'h00, 31'd0);
    send_request(OP_SEL,    8'h00, 8'h00, 31'd0);
    send_request(OP_SEL,    8'h00, 8'h00, 31'h7FFF_FFFF);
    send_request(OP_SEL,    8'h00, 8'h00, 31'd254);
    send_request(OP_ADD,    8'h5A, 8'h01, 31'd0);
    send_request(OP_ADD,    8'hA5, 8'h00, 31'd0);
    send_request(OP_ALLOC,  8'h00, 8'h00, 31'd0);
    send_request(OP_SEL,    8'h00, 8'h00, 31'd255);
    send_request(OP_SEL,    8'h00, 8'h00, 31'd256);
    send_request(OP_ALLOC,  8'h00, 8'h00, 31'd0);
    send_request(OP_ADD,    8'h11, 8'h03, 31'd0);
    send_request(OP_UNUSED, 8'h00, 8'h00, 31'd0);
    send_request(OP_SEL,    8'h00, 8'h00, 31'd511);
    send_request(OP_ALLOC,  8'h00, 8'h00, 31'd0);
    send_request(OP_SEL,    8'h00, 8'h00, 31'd258);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 52; stall_pct <= 0;  end
        2: begin
          idle_pct = 0;
          stall_pct <= 52;
          // starve the result side so the block backs up into the request side
          hold_orders <= hold_orders + 1;
        end
        default: begin idle_pct = 11; stall_pct <= 11; end
      endcase
      for (int n = 0; n < PHASE_REQS; n++) begin
        roll = $urandom_range(99);
        // add often until MAX_PROCS + 4 adds have been sent, then mostly draw
        if (adds_sent < MAX_PROCS + 4)
          op = (roll < 45) ? OP_ADD : (roll < 65) ? OP_ALLOC :
               (roll < 95) ? OP_SEL : OP_UNUSED;
        else
          op = (roll < 6) ? OP_ADD : (roll < 12) ? OP_ALLOC :
               (roll < 95) ? OP_SEL : OP_UNUSED;
        case ($urandom_range(9))
          0:       tc = 8'h00;
          1:       tc = 8'hFF;
          default: tc = 8'($urandom_range(255));
        endcase
        case ($urandom_range(3))
          0:       rv = 31'($urandom_range(8191));
          default: rv = 31'($urandom);
        endcase
        send_request(op, 8'($urandom_range(255)), tc, rv);
      end
    end
    req_ch.valid <= 1'b0;
    stall_pct    <= 0;
    @(posedge clk);
    while (pick_open != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent: %0d add, %0d allocate, %0d select, %0d unused opcode",
             op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
             op_tally[OP_ADD], op_tally[OP_ALLOC], op_tally[OP_SEL], op_tally[OP_UNUSED]);
    $display("%0d results checked over four pacing phases and a %0d-cycle result hold-off",
             pick_results, HOLD_CYCLES);
    if (pick_fail == 0 && pick_open == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
rtl/lsp_pkg.sv
rtl/lsp_if.sv
rtl/lsp_cell.sv
rtl/lsp_mod.sv
rtl/lottery_scheduler_pick.sv
tb/sv/lsp_pick_check.sv
tb/sv/tb_top.sv
